// File: sv/snaa_pkg.sv
package snaa_pkg;

  localparam int VAL_W          = 64;
  localparam int ROW_W          = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;
  localparam int COUNT_BITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KIND    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PER_ROW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd3;

  // aggregate kinds
  localparam logic [1:0] KIND_MIN   = 2'd0;
  localparam logic [1:0] KIND_MAX   = 2'd1;
  localparam logic [1:0] KIND_SUM   = 2'd2;
  localparam logic [1:0] KIND_COUNT = 2'd3;

  // sum limit width codes
  localparam logic [1:0] WCODE_8  = 2'd0;
  localparam logic [1:0] WCODE_16 = 2'd1;
  localparam logic [1:0] WCODE_32 = 2'd2;
  localparam logic [1:0] WCODE_64 = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic       ignore_nulls;
    logic       per_row_mode;
    logic [1:0] width_code;
  } cfg_t;

  // classified row handed from the front to the back
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    is_null;
    logic                    per_row;
    logic                    close_first;
    logic                    open_new;
    logic                    last;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] aggregate;
    logic                    aggregate_is_null;
    logic [ROW_W-1:0]        row_count;
    logic                    sum_overflow;
    logic                    column_has_null;
    logic                    last_result;
  } res_t;

  function automatic logic signed [VAL_W-1:0] sum_bound(input logic [1:0] code);
    logic signed [VAL_W-1:0] b;
    case (code)
      WCODE_8:  b = 64'sd127;
      WCODE_16: b = 64'sd32767;
      WCODE_32: b = 64'sd2147483647;
      default:  b = 64'sh7FFF_FFFF_FFFF_FFFF;
    endcase
    return b;
  endfunction

endpackage

// File: sv/snaa_if.sv
interface snaa_in_if;
  import snaa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    value_is_null;
  logic                    partition_start;
  logic                    last_row;

  modport source (output valid, value, value_is_null, partition_start, last_row,
                  input ready);
  modport sink (input valid, value, value_is_null, partition_start, last_row,
                output ready);
endinterface

interface snaa_out_if;
  import snaa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] aggregate;
  logic                    aggregate_is_null;
  logic [ROW_W-1:0]        row_count;
  logic                    sum_overflow;
  logic                    column_has_null;
  logic                    last_result;

  modport source (output valid, aggregate, aggregate_is_null, row_count, sum_overflow,
                  column_has_null, last_result, input ready);
  modport sink (input valid, aggregate, aggregate_is_null, row_count, sum_overflow,
                column_has_null, last_result, output ready);
endinterface

interface snaa_cfg_if;
  import snaa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/snaa_front.sv
module snaa_front (
  input  logic           clk,
  input  logic           rst_n,
  snaa_in_if.sink        in_ch,
  input  snaa_pkg::cfg_t cfg,
  output snaa_pkg::cmd_t push_cmd,
  output logic           push_valid,
  input  logic           push_ready
);
  import snaa_pkg::*;

  logic open_r;
  logic open_nxt;
  logic accept;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign accept      = in_ch.valid && push_ready;

  always_comb begin
    push_cmd.value       = in_ch.value;
    push_cmd.is_null     = in_ch.value_is_null;
    push_cmd.per_row     = cfg.per_row_mode;
    push_cmd.close_first = in_ch.partition_start && open_r;
    push_cmd.open_new    = in_ch.partition_start || !open_r;
    push_cmd.last        = in_ch.last_row;
  end

  // track partition state as the back will see it; per-row words leave it alone
  always_comb begin
    open_nxt = open_r;
    if (accept && !cfg.per_row_mode) begin
      open_nxt = !in_ch.last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else begin
      open_r <= open_nxt;
    end
  end

endmodule

// File: sv/snaa_queue.sv
module snaa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  snaa_pkg::cmd_t wr_data,
  input  logic           wr_valid,
  output logic           wr_ready,
  output snaa_pkg::cmd_t rd_data,
  output logic           rd_valid,
  input  logic           rd_pop
);
  import snaa_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = (cnt_r != FULL_CNT);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

// File: sv/snaa_back.sv
module snaa_back #(
  parameter int COUNT_BITS = snaa_pkg::COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  snaa_pkg::cfg_t cfg,
  input  snaa_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  snaa_out_if.source     out_ch
);
  import snaa_pkg::*;

  localparam logic [VAL_W-1:0] CNT_LIMIT =
    (COUNT_BITS >= VAL_W) ? {VAL_W{1'b1}} : ((VAL_W'(1) << COUNT_BITS) - VAL_W'(1));
  localparam logic [ROW_W-1:0] ROWS_MAX = {ROW_W{1'b1}};

  logic signed [VAL_W-1:0] acc_r, acc_nxt;
  logic                    acc_null_r, acc_null_nxt;
  logic [ROW_W-1:0]        rows_r, rows_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    any_null_r, any_null_nxt;
  logic                    pend_r, pend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  res_t                    out_res_r, out_res_nxt;

  logic                    out_free;
  logic                    is_count;
  logic                    emits;

  // partition state after the optional open, then after this row's update
  logic signed [VAL_W-1:0] base_acc;
  logic                    base_null;
  logic [ROW_W-1:0]        base_rows;
  logic                    base_ovf;
  logic signed [VAL_W-1:0] upd_acc;
  logic                    upd_null;
  logic [ROW_W-1:0]        upd_rows;
  logic                    upd_ovf;

  logic signed [VAL_W:0]   bound_w, val_w, add_w, lo_lim, hi_lim;
  logic signed [VAL_W-1:0] bound;
  logic signed [VAL_W-1:0] add_a;
  logic                    row_counts;

  logic                    emit;
  logic signed [VAL_W-1:0] e_agg;
  logic                    e_null;
  logic [ROW_W-1:0]        e_rows;
  logic                    e_ovf;
  logic                    e_last;

  assign out_free = !out_valid_r || out_ch.ready;
  assign is_count = (cfg.kind == KIND_COUNT);
  assign emits    = cmd.per_row || cmd.close_first || cmd.last;

  always_comb begin
    base_acc  = cmd.open_new ? '0 : acc_r;
    base_null = cmd.open_new ? 1'b1 : acc_null_r;
    base_rows = cmd.open_new ? '0 : rows_r;
    base_ovf  = cmd.open_new ? 1'b0 : ovf_r;
  end

  // checked sum: compare against the limits before adding
  always_comb begin
    bound   = sum_bound(cfg.width_code);
    add_a   = base_null ? '0 : base_acc;
    bound_w = {1'b0, bound};
    val_w   = {cmd.value[VAL_W-1], cmd.value};
    add_w   = {add_a[VAL_W-1], add_a};
    lo_lim  = -bound_w - val_w;
    hi_lim  = bound_w - val_w;
  end

  assign row_counts = !cmd.is_null || !cfg.ignore_nulls;

  always_comb begin
    upd_rows = (base_rows == ROWS_MAX) ? base_rows : base_rows + 1'b1;
    upd_acc  = base_acc;
    upd_null = base_null;
    upd_ovf  = base_ovf;
    case (cfg.kind)
      KIND_COUNT: begin
        if (row_counts && ($unsigned(base_acc) < CNT_LIMIT)) begin
          upd_acc = base_acc + 1'b1;
        end
      end
      KIND_SUM: begin
        if (!cmd.is_null) begin
          upd_null = 1'b0;
          if (cmd.value < 1) begin
            if (lo_lim > add_w) begin
              upd_acc = -bound;
              upd_ovf = 1'b1;
            end else begin
              upd_acc = add_a + cmd.value;
            end
          end else if (hi_lim < add_w) begin
            upd_acc = bound;
            upd_ovf = 1'b1;
          end else begin
            upd_acc = add_a + cmd.value;
          end
        end
      end
      KIND_MIN: begin
        if (!cmd.is_null) begin
          upd_null = 1'b0;
          if (base_null || (cmd.value < base_acc)) begin
            upd_acc = cmd.value;
          end
        end
      end
      default: begin
        if (!cmd.is_null) begin
          upd_null = 1'b0;
          if (base_null || (cmd.value > base_acc)) begin
            upd_acc = cmd.value;
          end
        end
      end
    endcase
  end

  always_comb begin
    acc_nxt      = acc_r;
    acc_null_nxt = acc_null_r;
    rows_nxt     = rows_r;
    ovf_nxt      = ovf_r;
    pend_nxt     = pend_r;
    cmd_pop      = 1'b0;
    emit         = 1'b0;
    e_agg        = acc_r;
    e_null       = !is_count && acc_null_r;
    e_rows       = rows_r;
    e_ovf        = ovf_r;
    e_last       = 1'b0;

    if (pend_r) begin
      // second word of a start row that also ends the column
      if (out_free) begin
        emit         = 1'b1;
        e_last       = 1'b1;
        pend_nxt     = 1'b0;
        acc_nxt      = '0;
        acc_null_nxt = 1'b1;
        rows_nxt     = '0;
        ovf_nxt      = 1'b0;
      end
    end else if (cmd_valid && (!emits || out_free)) begin
      cmd_pop = 1'b1;
      if (cmd.per_row) begin
        emit   = 1'b1;
        e_rows = ROW_W'(1);
        e_ovf  = 1'b0;
        e_last = cmd.last;
        if (is_count) begin
          e_agg  = row_counts ? VAL_W'(1) : '0;
          e_null = 1'b0;
        end else begin
          e_agg  = cmd.value;
          e_null = cmd.is_null;
        end
      end else begin
        acc_nxt      = upd_acc;
        acc_null_nxt = upd_null;
        rows_nxt     = upd_rows;
        ovf_nxt      = upd_ovf;
        if (cmd.close_first) begin
          // close the open partition from the current state
          emit = 1'b1;
          if (cmd.last) begin
            pend_nxt = 1'b1;
          end
        end else if (cmd.last) begin
          emit         = 1'b1;
          e_agg        = upd_acc;
          e_null       = !is_count && upd_null;
          e_rows       = upd_rows;
          e_ovf        = upd_ovf;
          e_last       = 1'b1;
          acc_nxt      = '0;
          acc_null_nxt = 1'b1;
          rows_nxt     = '0;
          ovf_nxt      = 1'b0;
        end
      end
    end
  end

  always_comb begin
    any_null_nxt  = any_null_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (emit) begin
      out_valid_nxt                 = 1'b1;
      out_res_nxt.aggregate         = e_null ? '0 : e_agg;
      out_res_nxt.aggregate_is_null = e_null;
      out_res_nxt.row_count         = e_rows;
      out_res_nxt.sum_overflow      = e_ovf;
      out_res_nxt.column_has_null   = any_null_r || e_null;
      out_res_nxt.last_result       = e_last;
      any_null_nxt                  = e_last ? 1'b0 : (any_null_r || e_null);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      acc_null_r  <= 1'b1;
      rows_r      <= '0;
      ovf_r       <= 1'b0;
      any_null_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      acc_null_r  <= acc_null_nxt;
      rows_r      <= rows_nxt;
      ovf_r       <= ovf_nxt;
      any_null_r  <= any_null_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.aggregate         = out_res_r.aggregate;
  assign out_ch.aggregate_is_null = out_res_r.aggregate_is_null;
  assign out_ch.row_count         = out_res_r.row_count;
  assign out_ch.sum_overflow      = out_res_r.sum_overflow;
  assign out_ch.column_has_null   = out_res_r.column_has_null;
  assign out_ch.last_result       = out_res_r.last_result;

endmodule

// File: sv/segmented_null_aware_aggregator_top.sv
// Segmented null-aware aggregator: takes one column row per cycle while the
// queue has room and keeps a running min, max, checked sum or count for the
// open partition, writing one result word when a partition closes (or one
// per row in per-row mode). The front stage classifies each row against its
// own copy of the partition state and pushes it into a two-entry queue; the
// back stage updates the accumulator and writes results into a single
// output register. Sustained rate is one row per cycle while the output is
// not stalled; a start row that closes an open partition and also ends the
// column yields two words and holds the back stage until both are written.
// Configuration writes are taken at any time (ready is always high) but must
// only happen while no row is in flight.
module segmented_null_aware_aggregator_top #(
  parameter int COUNT_BITS = snaa_pkg::COUNT_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  snaa_in_if.sink    in_ch,
  snaa_out_if.source out_ch,
  snaa_cfg_if.sink   cfg_ch
);
  import snaa_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  cmd_t push_cmd, head_cmd;
  logic push_valid, push_ready;
  logic head_valid, head_pop;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_KIND:    cfg_nxt.kind         = cfg_ch.data[1:0];
        REG_IGNORE:  cfg_nxt.ignore_nulls = cfg_ch.data[0];
        REG_PER_ROW: cfg_nxt.per_row_mode = cfg_ch.data[0];
        REG_WIDTH:   cfg_nxt.width_code   = cfg_ch.data[1:0];
        default:     cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kind         <= KIND_MIN;
      cfg_r.ignore_nulls <= 1'b1;
      cfg_r.per_row_mode <= 1'b0;
      cfg_r.width_code   <= WCODE_64;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  snaa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  snaa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (push_cmd),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .rd_data  (head_cmd),
    .rd_valid (head_valid),
    .rd_pop   (head_pop)
  );

  snaa_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (head_cmd),
    .cmd_valid (head_valid),
    .cmd_pop   (head_pop),
    .out_ch    (out_ch)
  );

endmodule

// File: sim/segmented_null_aware_aggregator_top_tb.sv
module segmented_null_aware_aggregator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import snaa_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ROWS   = 1426;

  localparam logic signed [VAL_W-1:0] MAX_VAL   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] MIN_VAL   = 64'sh8000_0000_0000_0000;
  localparam logic [63:0]             COUNT_MAX = (COUNT_BITS_DEF >= 64) ? '1 :
                                                  (64'd1 << COUNT_BITS_DEF) - 64'd1;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    is_null;
    logic                    start;
    logic                    last;
  } column_row_t;

  logic clk;
  logic rst_n;

  snaa_in_if  in_ch ();
  snaa_out_if out_ch ();
  snaa_cfg_if cfg_ch ();

  segmented_null_aware_aggregator_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // register shadows, reset values
  logic [1:0] kind_q    = KIND_MIN;
  logic       ignore_q  = 1'b1;
  logic       per_row_q = 1'b0;
  logic [1:0] wcode_q   = WCODE_64;

  // partition state of the aggregate predictor
  logic signed [VAL_W-1:0] acc           = '0;
  logic                    acc_null      = 1'b1;
  logic [ROW_W-1:0]        part_rows     = '0;
  logic                    part_open     = 1'b0;
  logic                    ovf_seen      = 1'b0;
  logic                    col_null_seen = 1'b0;

  column_row_t rows_to_send[$];
  column_row_t row_on_bus;
  res_t        expected_aggregates[$];

  int          rows_queued = 0;
  int          rows_taken  = 0;
  int          error_count = 0;
  int          idle_cycles = 0;
  int          burst_left  = 1;
  int          gap_left    = 0;
  int          stall_mode  = 0;
  int unsigned stall_tick  = 0;

  always #5ns clk = ~clk;

  function automatic longint sum_limit(input logic [1:0] code);
    longint one;
    one = 1;
    return (one << ((8 << code) - 1)) - 1;
  endfunction

  function void emit_result(input logic signed [VAL_W-1:0] agg, input logic is_null,
                            input logic [ROW_W-1:0] rows, input logic ovf, input logic last);
    res_t r;
    if (is_null) col_null_seen = 1'b1;
    r.aggregate         = is_null ? '0 : agg;
    r.aggregate_is_null = is_null;
    r.row_count         = rows;
    r.sum_overflow      = ovf;
    r.column_has_null   = col_null_seen;
    r.last_result       = last;
    expected_aggregates.push_back(r);
    if (last) col_null_seen = 1'b0;
  endfunction

  function void close_partition(input logic last);
    emit_result(acc, (kind_q == KIND_COUNT) ? 1'b0 : acc_null, part_rows, ovf_seen, last);
  endfunction

  function void predict_row(input column_row_t r);
    logic [63:0] cnt;
    longint      m;
    longint      a;
    longint      v;
    if (per_row_q) begin
      if (kind_q == KIND_COUNT)
        emit_result((r.is_null && ignore_q) ? 64'sd0 : 64'sd1, 1'b0, ROW_W'(1), 1'b0,
                    r.last);
      else
        emit_result(r.value, r.is_null, ROW_W'(1), 1'b0, r.last);
      return;
    end
    if (r.start && part_open) close_partition(1'b0);
    if (r.start || !part_open) begin
      acc       = '0;
      acc_null  = 1'b1;
      part_rows = '0;
      ovf_seen  = 1'b0;
      part_open = 1'b1;
    end
    if (part_rows != '1) part_rows++;
    if (kind_q == KIND_COUNT) begin
      if (!r.is_null || !ignore_q) begin
        cnt = acc;
        if (cnt < COUNT_MAX) cnt++;
        acc = cnt;
      end
    end else if (!r.is_null) begin
      if (kind_q == KIND_SUM) begin
        // saturate where the sum leaves; sums past a new bound stay unless pushed out
        m = sum_limit(wcode_q);
        a = acc_null ? 0 : acc;
        v = r.value;
        acc_null = 1'b0;
        if (v < 1 && -m - v > a) begin
          acc      = -m;
          ovf_seen = 1'b1;
        end else if (v >= 1 && m - v < a) begin
          acc      = m;
          ovf_seen = 1'b1;
        end else begin
          acc = a + v;
        end
      end else if (acc_null) begin
        acc      = r.value;
        acc_null = 1'b0;
      end else if (kind_q == KIND_MIN) begin
        if (r.value < acc) acc = r.value;
      end else if (r.value > acc) begin
        acc = r.value;
      end
    end
    if (r.last) begin
      close_partition(1'b1);
      acc       = '0;
      acc_null  = 1'b1;
      part_rows = '0;
      ovf_seen  = 1'b0;
      part_open = 1'b0;
    end
  endfunction

  task automatic log_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) log_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic queue_row(input logic signed [VAL_W-1:0] value, input logic is_null,
                           input logic start, input logic last);
    column_row_t r;
    r.value   = value;
    r.is_null = is_null;
    r.start   = start;
    r.last    = last;
    rows_to_send.push_back(r);
    rows_queued++;
  endtask

  task automatic wait_until_drained();
    do @(posedge clk);
    while (rows_taken != rows_queued || expected_aggregates.size() != 0);
    // let rows that close nothing leave the pipeline
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [1:0] kind, input logic ign,
                                input logic per_row, input logic [1:0] wcode);
    logic [CFG_IDX_W-1:0]  regs[4];
    logic [CFG_DATA_W-1:0] vals[4];
    regs[0] = REG_KIND;    vals[0] = CFG_DATA_W'(kind);
    regs[1] = REG_IGNORE;  vals[1] = CFG_DATA_W'(ign);
    regs[2] = REG_PER_ROW; vals[2] = CFG_DATA_W'(per_row);
    regs[3] = REG_WIDTH;   vals[3] = CFG_DATA_W'(wcode);
    for (int i = 0; i < 4; i++) begin
      cfg_ch.index <= regs[i];
      cfg_ch.data  <= vals[i];
      cfg_ch.valid <= 1'b1;
      do @(posedge clk);
      while (!cfg_ch.ready);
      case (regs[i])
        REG_KIND:    kind_q    = vals[i][1:0];
        REG_IGNORE:  ignore_q  = vals[i][0];
        REG_PER_ROW: per_row_q = vals[i][0];
        default:     wcode_q   = vals[i][1:0];
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // row driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid           <= 1'b0;
      in_ch.value           <= '0;
      in_ch.value_is_null   <= 1'b0;
      in_ch.partition_start <= 1'b0;
      in_ch.last_row        <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_row(row_on_bus);
        rows_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (rows_to_send.size() > 0) begin
          row_on_bus = rows_to_send.pop_front();
          in_ch.value           <= row_on_bus.value;
          in_ch.value_is_null   <= row_on_bus.is_null;
          in_ch.partition_start <= row_on_bus.start;
          in_ch.last_row        <= row_on_bus.last;
          in_ch.valid           <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_aggregates.size() == 0) begin
          log_mismatch("result word with nothing expected");
        end else begin
          want = expected_aggregates.pop_front();
          compare_field("aggregate", out_ch.aggregate, want.aggregate);
          compare_field("aggregate_is_null", 64'(out_ch.aggregate_is_null),
                        64'(want.aggregate_is_null));
          compare_field("row_count", 64'(out_ch.row_count), 64'(want.row_count));
          compare_field("sum_overflow", 64'(out_ch.sum_overflow),
                        64'(want.sum_overflow));
          compare_field("column_has_null", 64'(out_ch.column_has_null),
                        64'(want.column_has_null));
          compare_field("last_result", 64'(out_ch.last_result),
                        64'(want.last_result));
        end
      end
      stall_tick++;
      if (stall_tick % 200 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (stall_tick % 7) < 4;
      endcase
    end
  end

  // abort when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[segmented_null_aware_aggregator_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int          remaining;
    int          phase;
    int          phase_rows;
    int          plen;
    int          null_pct;
    int          s;
    logic        all_null;
    logic        start;
    logic        last;
    logic [1:0]  kind;
    logic [1:0]  wcode;
    longint      bound;
    logic signed [VAL_W-1:0] v;

    clk                   = 1'b0;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.value           = '0;
    in_ch.value_is_null   = 1'b0;
    in_ch.partition_start = 1'b0;
    in_ch.last_row        = 1'b0;
    out_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // min: implicit open, extremes, null skipped, start plus last closes twice,
    // then an all-null partition
    apply_settings(KIND_MIN, 1'b1, 1'b0, WCODE_64);
    queue_row(MAX_VAL, 1'b0, 1'b0, 1'b0);
    queue_row(MIN_VAL, 1'b0, 1'b0, 1'b0);
    queue_row(64'sd5, 1'b1, 1'b0, 1'b0);
    queue_row(64'sd3, 1'b0, 1'b1, 1'b1);
    queue_row(64'sd9, 1'b1, 1'b1, 1'b0);
    queue_row(-64'sd9, 1'b1, 1'b0, 1'b1);
    wait_until_drained();

    apply_settings(KIND_MAX, 1'b1, 1'b0, WCODE_64);
    queue_row(-64'sd1, 1'b0, 1'b1, 1'b0);
    queue_row(MAX_VAL, 1'b0, 1'b0, 1'b0);
    queue_row(64'sd0, 1'b1, 1'b0, 1'b1);
    wait_until_drained();

    // checked sum at the narrowest bound: overflow both ways
    apply_settings(KIND_SUM, 1'b1, 1'b0, WCODE_8);
    queue_row(64'sd100, 1'b0, 1'b1, 1'b0);
    queue_row(64'sd100, 1'b0, 1'b0, 1'b0);
    queue_row(-64'sd300, 1'b0, 1'b0, 1'b0);
    queue_row(MIN_VAL, 1'b0, 1'b0, 1'b1);
    wait_until_drained();

    apply_settings(KIND_SUM, 1'b0, 1'b0, WCODE_64);
    queue_row(MAX_VAL, 1'b0, 1'b1, 1'b0);
    queue_row(64'sd1, 1'b0, 1'b0, 1'b1);
    queue_row(MIN_VAL, 1'b0, 1'b1, 1'b1);
    wait_until_drained();

    apply_settings(KIND_COUNT, 1'b0, 1'b0, WCODE_16);
    queue_row(64'sd7, 1'b1, 1'b1, 1'b0);
    queue_row(64'sd7, 1'b0, 1'b0, 1'b1);
    wait_until_drained();

    apply_settings(KIND_COUNT, 1'b1, 1'b0, WCODE_32);
    queue_row(64'sd7, 1'b1, 1'b1, 1'b0);
    queue_row(64'sd7, 1'b0, 1'b0, 1'b1);
    wait_until_drained();

    apply_settings(KIND_COUNT, 1'b1, 1'b1, WCODE_64);
    queue_row(64'sd7, 1'b1, 1'b0, 1'b0);
    queue_row(64'sd7, 1'b0, 1'b0, 1'b1);
    wait_until_drained();

    apply_settings(KIND_MIN, 1'b1, 1'b1, WCODE_64);
    queue_row(-64'sd5, 1'b0, 1'b0, 1'b0);
    queue_row(64'sd4, 1'b1, 1'b0, 1'b1);
    wait_until_drained();

    // random phases; partitions may stay open across a register change
    remaining = RANDOM_ROWS;
    phase     = 0;
    while (remaining > 0) begin
      kind  = (phase < 4) ? KIND_SUM : 2'($urandom_range(0, 3));
      wcode = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
      apply_settings(kind, 1'($urandom_range(0, 1)),
                     (phase >= 4) && ($urandom_range(0, 5) == 0), wcode);
      case ($urandom_range(0, 3))
        0:       null_pct = 0;
        1:       null_pct = 10;
        2:       null_pct = 35;
        default: null_pct = 80;
      endcase
      phase_rows = $urandom_range(40, 90);
      if (phase_rows > remaining) phase_rows = remaining;
      remaining -= phase_rows;
      while (phase_rows > 0) begin
        plen     = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        all_null = ($urandom_range(0, 7) == 0);
        for (int j = 0; j < plen && phase_rows > 0; j++) begin
          start = (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
          last  = (j == plen - 1) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 79) == 0);
          bound = sum_limit(2'($urandom_range(0, 3)));
          case ($urandom_range(0, 9))
            0, 1, 2: begin
              s = int'($urandom_range(0, 400)) - 200;
              v = VAL_W'(s);
            end
            3, 4: begin
              s = int'($urandom_range(0, 80000)) - 40000;
              v = VAL_W'(s);
            end
            5: begin
              s = int'($urandom);
              v = VAL_W'(s);
            end
            6: begin
              // hover around a sum bound
              v = bound + int'($urandom_range(0, 4)) - 2;
              if ($urandom_range(0, 1)) v = -v;
            end
            7: begin
              case ($urandom_range(0, 4))
                0:       v = MAX_VAL;
                1:       v = MIN_VAL;
                2:       v = 64'sd0;
                3:       v = -64'sd1;
                default: v = 64'sd1;
              endcase
            end
            default: v = {$urandom, $urandom};
          endcase
          queue_row(v, all_null || ($urandom_range(0, 99) < null_pct), start, last);
          phase_rows--;
        end
      end
      wait_until_drained();
      phase++;
    end

    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("[segmented_null_aware_aggregator_top] OK");
    else
      $display("[segmented_null_aware_aggregator_top] ERROR");
    $finish;
  end

endmodule
